[rtl/shell_word_splitter_core_macros.svh]
// Assertion macros for the shell word splitter RTL.
`ifndef SHELL_WORD_SPLITTER_CORE_MACROS_SVH
`define SHELL_WORD_SPLITTER_CORE_MACROS_SVH

// Check a property on every clock edge while out of reset.
`define SWS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check a property on every clock edge, reset included.
`define SWS_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

[rtl/swsplit_pkg.sv]
`timescale 1ns / 1ps

package swsplit_pkg;

  // Quote context stack sizing
  localparam int QUOTE_DEPTH = 16;
  localparam int CNT_W       = $clog2(QUOTE_DEPTH + 1);
  localparam int IDX_W       = $clog2(QUOTE_DEPTH);

  // Result queue sizing (two slots free are needed to take an item)
  localparam int RQ_DEPTH = 4;
  localparam int RQ_PW    = $clog2(RQ_DEPTH);
  localparam int RQ_CW    = $clog2(RQ_DEPTH + 1);

  // Byte constants
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_BSL    = 8'h5C;
  localparam logic [7:0] CH_SQ     = 8'h27;
  localparam logic [7:0] CH_DQ     = 8'h22;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_HASH   = 8'h23;
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_VT     = 8'h0B;
  localparam logic [7:0] CH_FF     = 8'h0C;
  localparam logic [7:0] CH_CR     = 8'h0D;

  typedef enum logic [1:0] {
    CTX_BSL   = 2'd0,
    CTX_SQ    = 2'd1,
    CTX_DQ    = 2'd2,
    CTX_PAREN = 2'd3
  } ctx_e;

  typedef enum logic [2:0] {
    KIND_BYTE = 3'd0,
    KIND_EOW  = 3'd1,
    KIND_SEP  = 3'd2,
    KIND_ERR  = 3'd3,
    KIND_DONE = 3'd4
  } kind_e;

  typedef enum logic {
    ERR_BRACKET = 1'b0,
    ERR_DEPTH   = 1'b1
  } err_e;

  typedef enum logic {
    ACT_BYTE  = 1'b0,
    ACT_FLUSH = 1'b1
  } action_e;

  typedef struct packed {
    kind_e      kind;
    logic [7:0] out_char;
    err_e       error_code;
    logic       last;
  } result_t;

  typedef struct packed {
    logic in_comment;
    logic skip_space;
    logic after_dollar;
    logic word_nonempty;
    logic failed;
  } flags_t;

  localparam flags_t FLAGS_RST = '{
    in_comment:    1'b0,
    skip_space:    1'b1,
    after_dollar:  1'b0,
    word_nonempty: 1'b0,
    failed:        1'b0
  };

  localparam result_t RESULT_NONE = '{
    kind:       KIND_BYTE,
    out_char:   8'h00,
    error_code: ERR_BRACKET,
    last:       1'b0
  };

endpackage

[rtl/swsplit_step.sv]
`timescale 1ns / 1ps

module swsplit_step (
  input  logic                             action_i,
  input  logic [7:0]                       ch_i,
  input  swsplit_pkg::flags_t              flags_i,
  input  logic [swsplit_pkg::CNT_W-1:0]    cnt_i,
  input  swsplit_pkg::ctx_e                top_i,
  output swsplit_pkg::flags_t              flags_o,
  output logic [swsplit_pkg::CNT_W-1:0]    cnt_o,
  output logic                             push_o,
  output swsplit_pkg::ctx_e                push_ctx_o,
  output swsplit_pkg::result_t             res0_o,
  output swsplit_pkg::result_t             res1_o,
  output logic [1:0]                       res_n_o
);
  import swsplit_pkg::*;

  logic full;
  logic is_blank;
  logic is_quote;
  ctx_e quote_ctx;

  assign full     = (cnt_i == CNT_W'(QUOTE_DEPTH));
  assign is_blank = (ch_i == CH_SPACE) || (ch_i == CH_TAB) || (ch_i == CH_VT) ||
                    (ch_i == CH_FF) || (ch_i == CH_CR);
  assign is_quote = (ch_i == CH_BSL) || (ch_i == CH_SQ) || (ch_i == CH_DQ);
  assign quote_ctx = (ch_i == CH_BSL) ? CTX_BSL : (ch_i == CH_SQ) ? CTX_SQ : CTX_DQ;

  // Work out the next state and up to two results for one item
  always_comb begin
    logic need_push;
    logic pop;
    ctx_e nctx;
    flags_o    = flags_i;
    cnt_o      = cnt_i;
    push_o     = 1'b0;
    push_ctx_o = CTX_BSL;
    res0_o     = RESULT_NONE;
    res1_o     = RESULT_NONE;
    res_n_o    = 2'd0;
    need_push  = 1'b0;
    pop        = 1'b0;
    nctx       = CTX_BSL;

    if (action_i == ACT_FLUSH) begin
      // Flush the open word, report done, return to reset
      if (!flags_i.failed && flags_i.word_nonempty) begin
        res0_o.kind = KIND_EOW;
        res1_o.kind = KIND_DONE;
        res_n_o     = 2'd2;
      end else begin
        res0_o.kind = KIND_DONE;
        res_n_o     = 2'd1;
      end
      flags_o = FLAGS_RST;
      cnt_o   = '0;
    end else if (flags_i.failed) begin
      // Drop bytes until end of command
    end else if (flags_i.in_comment) begin
      flags_o.in_comment = (ch_i != CH_NL);
      flags_o.skip_space = 1'b1;
    end else if (cnt_i != '0) begin
      // Inside a quoting context: keep every byte unless a push would overflow the stack
      unique case (top_i)
        CTX_PAREN: begin
          if (ch_i == CH_RPAREN) begin
            pop = 1'b1;
          end else if (is_quote) begin
            need_push = 1'b1;
            nctx      = quote_ctx;
          end
        end
        CTX_BSL: pop = 1'b1;
        CTX_DQ: begin
          if (ch_i == CH_DQ) begin
            pop = 1'b1;
          end else if (flags_i.after_dollar && ch_i == CH_LPAREN) begin
            need_push = 1'b1;
            nctx      = CTX_PAREN;
          end
        end
        CTX_SQ: pop = (ch_i == CH_SQ);
        default: pop = 1'b0;
      endcase
      if (need_push && full) begin
        flags_o.failed    = 1'b1;
        res0_o.kind       = KIND_ERR;
        res0_o.error_code = ERR_DEPTH;
        res_n_o           = 2'd1;
      end else begin
        if (need_push) begin
          push_o     = 1'b1;
          push_ctx_o = nctx;
          cnt_o      = cnt_i + CNT_W'(1);
        end else if (pop) begin
          cnt_o = cnt_i - CNT_W'(1);
        end
        if (top_i == CTX_DQ) begin
          flags_o.after_dollar = (ch_i == CH_DOLLAR);
        end
        flags_o.word_nonempty = 1'b1;
        res0_o.kind           = KIND_BYTE;
        res0_o.out_char       = ch_i;
        res_n_o               = 2'd1;
      end
    end else if (ch_i == CH_NL || ch_i == CH_SEMI) begin
      // Statement separator, always preceded by an end of word
      res0_o.kind           = KIND_EOW;
      res1_o.kind           = KIND_SEP;
      res_n_o               = 2'd2;
      flags_o.word_nonempty = 1'b0;
      flags_o.skip_space    = 1'b1;
    end else if (ch_i == CH_RPAREN) begin
      flags_o.failed    = 1'b1;
      res0_o.kind       = KIND_ERR;
      res0_o.error_code = ERR_BRACKET;
      res_n_o           = 2'd1;
    end else if (is_quote && full) begin
      flags_o.failed    = 1'b1;
      res0_o.kind       = KIND_ERR;
      res0_o.error_code = ERR_DEPTH;
      res_n_o           = 2'd1;
    end else begin
      if (is_quote) begin
        push_o     = 1'b1;
        push_ctx_o = quote_ctx;
        cnt_o      = cnt_i + CNT_W'(1);
      end
      if (is_blank) begin
        if (!flags_i.skip_space) begin
          res0_o.kind           = KIND_EOW;
          res_n_o               = 2'd1;
          flags_o.word_nonempty = 1'b0;
        end
        flags_o.skip_space = 1'b1;
      end else begin
        flags_o.skip_space = 1'b0;
        if (ch_i == CH_HASH && !flags_i.word_nonempty) begin
          flags_o.in_comment = 1'b1;
        end else begin
          flags_o.word_nonempty = 1'b1;
          flags_o.after_dollar  = (ch_i == CH_DOLLAR);
          res0_o.kind           = KIND_BYTE;
          res0_o.out_char       = ch_i;
          res_n_o               = 2'd1;
        end
      end
    end

    // Mark the final result of this item
    res0_o.last = (res_n_o == 2'd1);
    res1_o.last = (res_n_o == 2'd2);
  end

endmodule

[rtl/swsplit_rq.sv]
`timescale 1ns / 1ps

module swsplit_rq (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic [1:0]           wr_n_i,
  input  swsplit_pkg::result_t wr0_i,
  input  swsplit_pkg::result_t wr1_i,
  output logic                 room_o,
  output logic                 valid_o,
  input  logic                 ready_i,
  output swsplit_pkg::result_t data_o
);
  import swsplit_pkg::*;

  result_t          ent_q [RQ_DEPTH];
  logic [RQ_PW-1:0] wr_ptr_q, wr_ptr_d, wr_ptr_p1;
  logic [RQ_PW-1:0] rd_ptr_q, rd_ptr_d;
  logic [RQ_CW-1:0] cnt_q, cnt_d;
  logic             pop;

  assign valid_o   = (cnt_q != '0);
  assign data_o    = ent_q[rd_ptr_q];
  assign pop       = valid_o && ready_i;
  assign room_o    = (cnt_q <= RQ_CW'(RQ_DEPTH - 2));
  assign wr_ptr_p1 = wr_ptr_q + RQ_PW'(1);

  // Advance pointers and fill level
  always_comb begin
    wr_ptr_d = wr_ptr_q + RQ_PW'(wr_n_i);
    rd_ptr_d = pop ? rd_ptr_q + RQ_PW'(1) : rd_ptr_q;
    cnt_d    = cnt_q + RQ_CW'(wr_n_i) - RQ_CW'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Store up to two results per cycle
  always_ff @(posedge clk_i) begin
    if (wr_n_i != 2'd0) begin
      ent_q[wr_ptr_q] <= wr0_i;
    end
    if (wr_n_i == 2'd2) begin
      ent_q[wr_ptr_p1] <= wr1_i;
    end
  end

endmodule

[rtl/shell_word_splitter_core.sv]
`timescale 1ns / 1ps
// Channel  Direction  Handshake                  Payload
// in       input      in_valid_i / in_ready_o    action_i, ch_i
// out      output     out_valid_o / out_ready_i  kind_o, out_char_o, error_code_o, last_o
//
// An item is decoded in the cycle it transfers; its results, up to two, are
// registered in a four-entry result queue and reach the output from there.
// Input takes one item per cycle while two queue slots are free; the output
// drains one result per cycle while out_ready_i is high, which paces two-result items.
// Reset clears the context stack count and flags; the stack entries need no clear.
// A stalled output holds the queue; input stalls once three results are waiting.

module shell_word_splitter_core (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic       action_i,
  input  logic [7:0] ch_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [2:0] kind_o,
  output logic [7:0] out_char_o,
  output logic       error_code_o,
  output logic       last_o
);
  import swsplit_pkg::*;

`include "shell_word_splitter_core_macros.svh"

  flags_t           flags_q, flags_d;
  logic [CNT_W-1:0] cnt_q, cnt_d, cnt_m1;
  ctx_e             stack_q [QUOTE_DEPTH];
  ctx_e             top_ctx;
  ctx_e             push_ctx;
  logic             push;
  logic             accept;
  result_t          res0, res1, out_res;
  logic [1:0]       res_n, wr_n;
  logic             room;

  assign accept  = in_valid_i && in_ready_o;
  assign cnt_m1  = cnt_q - CNT_W'(1);
  assign top_ctx = (cnt_q == '0) ? CTX_BSL : stack_q[cnt_m1[IDX_W-1:0]];

  // Decode one item against the current state
  swsplit_step u_step (
    .action_i   (action_i),
    .ch_i       (ch_i),
    .flags_i    (flags_q),
    .cnt_i      (cnt_q),
    .top_i      (top_ctx),
    .flags_o    (flags_d),
    .cnt_o      (cnt_d),
    .push_o     (push),
    .push_ctx_o (push_ctx),
    .res0_o     (res0),
    .res1_o     (res1),
    .res_n_o    (res_n)
  );

  // Update state on each transfer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flags_q <= FLAGS_RST;
      cnt_q   <= '0;
    end else if (accept) begin
      flags_q <= flags_d;
      cnt_q   <= cnt_d;
    end
  end

  // Push a new context on top of the stack
  always_ff @(posedge clk_i) begin
    if (accept && push) begin
      stack_q[cnt_q[IDX_W-1:0]] <= push_ctx;
    end
  end

  assign wr_n = accept ? res_n : 2'd0;

  // Queue results toward the output
  swsplit_rq u_rq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_n_i  (wr_n),
    .wr0_i   (res0),
    .wr1_i   (res1),
    .room_o  (room),
    .valid_o (out_valid_o),
    .ready_i (out_ready_i),
    .data_o  (out_res)
  );

  assign in_ready_o   = room;
  assign kind_o       = out_res.kind;
  assign out_char_o   = out_res.out_char;
  assign error_code_o = out_res.error_code;
  assign last_o       = out_res.last;

  `SWS_ASSERT(a_cnt_bound, cnt_q <= CNT_W'(QUOTE_DEPTH), "context count beyond depth")
  `SWS_ASSERT(a_failed_silent, (accept && action_i == ACT_BYTE && flags_q.failed) |-> (res_n == 2'd0), "result after failure")
  `SWS_ASSERT(a_flush_reset, (accept && action_i == ACT_FLUSH) |=> (cnt_q == '0 && flags_q == FLAGS_RST), "state not reset after end of command")

endmodule
